// File: sv/dcfp_pkg.sv
// ============================================================================
// dcfp_pkg - display command frame parser shared definitions
// Frame delimiters, command codes, status codes, register map and the
// structs that travel between the parser's modules.
// ============================================================================
package dcfp_pkg;

    localparam int unsigned PAYLOAD_HEAD_BYTES = 14;
    localparam int unsigned ADDR_W             = 3;
    localparam int unsigned COUNT_W            = 9;

    localparam logic [7:0]         STX           = 8'h7B;
    localparam logic [7:0]         ETX           = 8'h7D;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 9'd511;
    localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 9'd4;
    localparam logic [COUNT_W-1:0] CFG_MIN_RESET = 9'd4;
    localparam logic [COUNT_W-1:0] CFG_MAX_RESET = 9'd257;

    // register index, taken from paddr[2]
    localparam logic REG_MIN_FRAME = 1'b0;
    localparam logic REG_MAX_FRAME = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FRAME_ERR   = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_PARAM_ERR   = 2'd3
    } t_status;

    localparam logic [7:0] CMD_FILL_COLOR  = 8'h01;
    localparam logic [7:0] CMD_CTRL_02     = 8'h02;
    localparam logic [7:0] CMD_NOARG_31    = 8'h31;
    localparam logic [7:0] CMD_NOARG_32    = 8'h32;
    localparam logic [7:0] CMD_LINE_TEXT   = 8'h33;
    localparam logic [7:0] CMD_SCREEN_TEXT = 8'h34;
    localparam logic [7:0] CMD_NOARG_35    = 8'h35;
    localparam logic [7:0] CMD_BRIGHTNESS  = 8'h38;
    localparam logic [7:0] CMD_PERIPHERAL  = 8'h41;
    localparam logic [7:0] CMD_ROW_CLR_0   = 8'h42;
    localparam logic [7:0] CMD_ROW_CLR_1   = 8'h43;
    localparam logic [7:0] CMD_ROW_CLR_2   = 8'h44;
    localparam logic [7:0] CMD_ROW_CLR_3   = 8'h45;
    localparam logic [7:0] CMD_ROW_CLR_4   = 8'h46;
    localparam logic [7:0] CMD_NETWORK     = 8'h47;
    localparam logic [7:0] CMD_NOARG_48    = 8'h48;
    localparam logic [7:0] CMD_FONT        = 8'h49;
    localparam logic [7:0] CMD_ROW_CLR_ALL = 8'h50;

    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_ONE    = 8'h31;
    localparam logic [7:0] ASCII_TWO    = 8'h32;
    localparam logic [7:0] ASCII_FIVE   = 8'h35;
    localparam logic [7:0] ASCII_EIGHT  = 8'h38;
    localparam logic [7:0] BIN_COLOR_MAX = 8'h02;
    localparam logic [7:0] BIN_ROW_MAX   = 8'h05;
    localparam logic [7:0] FILL_MAX      = 8'd7;
    localparam logic [7:0] FONT_TYPE_MAX = 8'd3;
    localparam logic [7:0] FONT_SIZE_MAX = 8'd2;
    localparam logic [7:0] ROW_ALL_CODE  = 8'd5;
    localparam logic [7:0] NET_HEAD_LEN  = 8'd14;

    typedef struct packed {
        logic [COUNT_W-1:0] len;       // count including the current byte
        logic               start_ok;
        logic [7:0]         command;
        logic [7:0]         decl_len;
    } t_frame_info;

    typedef struct packed {
        t_status     status;
        logic [7:0]  command;
        logic [7:0]  param_a;
        logic [7:0]  param_b;
        logic [7:0]  param_c;
        logic [7:0]  text_count;
        logic [31:0] ip_address;
        logic [31:0] net_mask;
        logic [31:0] gateway;
        logic [15:0] port_number;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } t_code;

    // ASCII '0'..'2' or binary 0..2
    function automatic t_code decode_color(input logic [7:0] b);
        t_code c;
        c.ok  = 1'b0;
        c.val = 8'd0;
        if (b >= ASCII_ZERO && b <= ASCII_TWO) begin
            c.ok  = 1'b1;
            c.val = b - ASCII_ZERO;
        end else if (b <= BIN_COLOR_MAX) begin
            c.ok  = 1'b1;
            c.val = b;
        end
        return c;
    endfunction

    // ASCII '1'..'5' or binary 1..5, both to row 0..4
    function automatic t_code decode_row(input logic [7:0] b);
        t_code c;
        c.ok  = 1'b0;
        c.val = 8'd0;
        if (b >= ASCII_ONE && b <= ASCII_FIVE) begin
            c.ok  = 1'b1;
            c.val = b - ASCII_ONE;
        end else if (b >= 8'd1 && b <= BIN_ROW_MAX) begin
            c.ok  = 1'b1;
            c.val = b - 8'd1;
        end
        return c;
    endfunction

endpackage

// File: sv/dcfp_if.sv
// ============================================================================
// dcfp_if - parser stream interfaces
// Valid/ready channels for incoming frame bytes and for parse results.
// ============================================================================
interface dcfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface dcfp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  command;
    logic [7:0]  param_a;
    logic [7:0]  param_b;
    logic [7:0]  param_c;
    logic [7:0]  text_count;
    logic [31:0] ip_address;
    logic [31:0] net_mask;
    logic [31:0] gateway;
    logic [15:0] port_number;

    modport source (
        output valid, output status, output command, output param_a, output param_b,
        output param_c, output text_count, output ip_address, output net_mask,
        output gateway, output port_number, input ready
    );
    modport sink (
        input valid, input status, input command, input param_a, input param_b,
        input param_c, input text_count, input ip_address, input net_mask,
        input gateway, input port_number, output ready
    );
endinterface

// File: sv/dcfp_cfg_regs.sv
// ============================================================================
// dcfp_cfg_regs - frame length limit registers
// APB-style write/read access to the minimum and maximum frame length.
// ============================================================================
module dcfp_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dcfp_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic [dcfp_pkg::COUNT_W-1:0]        o_min_frame,
    output logic [dcfp_pkg::COUNT_W-1:0]        o_max_frame
);

    logic [dcfp_pkg::COUNT_W-1:0] r_min_frame;
    logic [dcfp_pkg::COUNT_W-1:0] r_max_frame;
    logic                         wr_en;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_frame <= dcfp_pkg::CFG_MIN_RESET;
            r_max_frame <= dcfp_pkg::CFG_MAX_RESET;
        end else if (wr_en) begin
            if (reg_sel == dcfp_pkg::REG_MIN_FRAME) begin
                r_min_frame <= pwdata[dcfp_pkg::COUNT_W-1:0];
            end else begin
                r_max_frame <= pwdata[dcfp_pkg::COUNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == dcfp_pkg::REG_MIN_FRAME) begin
            prdata = {{(32-dcfp_pkg::COUNT_W){1'b0}}, r_min_frame};
        end else begin
            prdata = {{(32-dcfp_pkg::COUNT_W){1'b0}}, r_max_frame};
        end
    end

    assign o_min_frame = r_min_frame;
    assign o_max_frame = r_max_frame;

endmodule

// File: sv/dcfp_frame_track.sv
// ============================================================================
// dcfp_frame_track - per-frame byte tracking
// Counts frame bytes, captures start flag, command, length byte and the
// head of the parameter payload.
// ============================================================================
module dcfp_frame_track #(
    parameter int unsigned PAYLOAD_HEAD_BYTES = dcfp_pkg::PAYLOAD_HEAD_BYTES
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [7:0]                            i_data_byte,
    input  logic                                  i_frame_end,
    output dcfp_pkg::t_frame_info                 o_info,
    output logic [PAYLOAD_HEAD_BYTES-1:0][7:0]    o_head
);

    localparam int unsigned IDX_W = $clog2(PAYLOAD_HEAD_BYTES);
    localparam logic [dcfp_pkg::COUNT_W-1:0] HEAD_BASE = 9'd3;

    logic [dcfp_pkg::COUNT_W-1:0]       r_count;
    logic [dcfp_pkg::COUNT_W-1:0]       n_count;
    logic                               r_start_ok;
    logic [7:0]                         r_command;
    logic [7:0]                         r_decl_len;
    logic [PAYLOAD_HEAD_BYTES-1:0][7:0] r_head;
    logic [dcfp_pkg::COUNT_W-1:0]       head_off;
    logic                               head_wr;

    assign n_count  = (r_count == dcfp_pkg::COUNT_MAX) ? r_count : r_count + 9'd1;
    assign head_off = r_count - HEAD_BASE;
    assign head_wr  = i_accept && (r_count >= HEAD_BASE)
                      && (head_off < dcfp_pkg::COUNT_W'(PAYLOAD_HEAD_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_start_ok <= 1'b0;
            r_command  <= '0;
            r_decl_len <= '0;
        end else if (i_accept) begin
            if (i_frame_end) begin
                // frame done: back to idle
                r_count    <= '0;
                r_start_ok <= 1'b0;
                r_command  <= '0;
                r_decl_len <= '0;
            end else begin
                r_count <= n_count;
                if (r_count == 9'd0) begin
                    r_start_ok <= (i_data_byte == dcfp_pkg::STX);
                end
                if (r_count == 9'd1) begin
                    r_command <= i_data_byte;
                end
                if (r_count == 9'd2) begin
                    r_decl_len <= i_data_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_wr) begin
            r_head[head_off[IDX_W-1:0]] <= i_data_byte;
        end
    end

    assign o_info.len      = n_count;
    assign o_info.start_ok = r_start_ok;
    assign o_info.command  = r_command;
    assign o_info.decl_len = r_decl_len;
    assign o_head          = r_head;

endmodule

// File: sv/dcfp_decode.sv
// ============================================================================
// dcfp_decode - frame check and command decode
// Checks framing on the last byte and applies each command's parameter
// rules to the captured payload head.
// ============================================================================
module dcfp_decode #(
    parameter int unsigned PAYLOAD_HEAD_BYTES = dcfp_pkg::PAYLOAD_HEAD_BYTES
) (
    input  dcfp_pkg::t_frame_info               i_info,
    input  logic [PAYLOAD_HEAD_BYTES-1:0][7:0]  i_head,
    input  logic [7:0]                          i_data_byte,
    input  logic [dcfp_pkg::COUNT_W-1:0]        i_min_frame,
    input  logic [dcfp_pkg::COUNT_W-1:0]        i_max_frame,
    output dcfp_pkg::t_result                   o_result
);

    logic              framed;
    logic [7:0]        d;
    logic [7:0]        p0;
    logic [7:0]        p1;
    logic [7:0]        p2;
    dcfp_pkg::t_code   color;
    dcfp_pkg::t_code   row;
    dcfp_pkg::t_result res;

    assign d     = i_info.decl_len;
    assign p0    = i_head[0];
    assign p1    = i_head[1];
    assign p2    = i_head[2];
    assign color = dcfp_pkg::decode_color(p0);
    assign row   = dcfp_pkg::decode_row(p1);

    assign framed = (i_info.len >= dcfp_pkg::MIN_FRAME_LEN)
                    && (i_info.len >= i_min_frame)
                    && (i_info.len <= i_max_frame)
                    && i_info.start_ok
                    && (i_data_byte == dcfp_pkg::ETX)
                    && ((i_info.len - dcfp_pkg::MIN_FRAME_LEN) == {1'b0, d});

    always_comb begin
        res         = '0;
        res.status  = dcfp_pkg::ST_OK;
        res.command = i_info.command;
        case (i_info.command)
            dcfp_pkg::CMD_NOARG_31, dcfp_pkg::CMD_NOARG_32,
            dcfp_pkg::CMD_NOARG_35, dcfp_pkg::CMD_NOARG_48: begin
                if (d != 8'd0) res.status = dcfp_pkg::ST_PARAM_ERR;
            end
            dcfp_pkg::CMD_LINE_TEXT: begin
                if (d < 8'd3 || !color.ok || !row.ok) begin
                    res.status = dcfp_pkg::ST_PARAM_ERR;
                end
                res.param_a    = color.val;
                res.param_b    = row.val;
                res.text_count = d - 8'd2;
            end
            dcfp_pkg::CMD_SCREEN_TEXT: begin
                if (d < 8'd4 || !color.ok) res.status = dcfp_pkg::ST_PARAM_ERR;
                res.param_a    = color.val;
                res.param_b    = p1;
                res.param_c    = p2;
                res.text_count = d - 8'd3;
            end
            dcfp_pkg::CMD_BRIGHTNESS: begin
                if (d != 8'd1) begin
                    res.status = dcfp_pkg::ST_PARAM_ERR;
                end else if (p0 == 8'd0 || p0 == dcfp_pkg::ASCII_ZERO) begin
                    res.param_a = 8'd0;
                end else if (p0 >= dcfp_pkg::ASCII_ONE && p0 <= dcfp_pkg::ASCII_EIGHT) begin
                    res.param_a = p0 - dcfp_pkg::ASCII_ZERO;
                end else begin
                    res.status = dcfp_pkg::ST_PARAM_ERR;
                end
            end
            dcfp_pkg::CMD_PERIPHERAL: begin
                if (d != 8'd1) res.status = dcfp_pkg::ST_PARAM_ERR;
                res.param_a = p0;
            end
            dcfp_pkg::CMD_ROW_CLR_0, dcfp_pkg::CMD_ROW_CLR_1, dcfp_pkg::CMD_ROW_CLR_2,
            dcfp_pkg::CMD_ROW_CLR_3, dcfp_pkg::CMD_ROW_CLR_4: begin
                if (d != 8'd0) res.status = dcfp_pkg::ST_PARAM_ERR;
                res.param_a = i_info.command - dcfp_pkg::CMD_ROW_CLR_0;
            end
            dcfp_pkg::CMD_ROW_CLR_ALL: begin
                if (d != 8'd0) res.status = dcfp_pkg::ST_PARAM_ERR;
                res.param_a = dcfp_pkg::ROW_ALL_CODE;
            end
            dcfp_pkg::CMD_NETWORK: begin
                if (d < dcfp_pkg::NET_HEAD_LEN) res.status = dcfp_pkg::ST_PARAM_ERR;
                res.ip_address  = {i_head[0], i_head[1], i_head[2], i_head[3]};
                res.net_mask    = {i_head[4], i_head[5], i_head[6], i_head[7]};
                res.gateway     = {i_head[8], i_head[9], i_head[10], i_head[11]};
                res.port_number = {i_head[12], i_head[13]};
            end
            dcfp_pkg::CMD_FONT: begin
                if (d != 8'd2 || p0 > dcfp_pkg::FONT_TYPE_MAX
                    || p1 > dcfp_pkg::FONT_SIZE_MAX) begin
                    res.status = dcfp_pkg::ST_PARAM_ERR;
                end
                res.param_a = p0;
                res.param_b = p1;
            end
            dcfp_pkg::CMD_FILL_COLOR: begin
                if (d != 8'd1 || p0 < 8'd1 || p0 > dcfp_pkg::FILL_MAX) begin
                    res.status = dcfp_pkg::ST_PARAM_ERR;
                end
                res.param_a = p0;
            end
            dcfp_pkg::CMD_CTRL_02: begin
                if (d != 8'd1) res.status = dcfp_pkg::ST_PARAM_ERR;
            end
            default: begin
                res.status = dcfp_pkg::ST_UNSUPPORTED;
            end
        endcase

        o_result = '0;
        if (!framed) begin
            o_result.status = dcfp_pkg::ST_FRAME_ERR;
        end else if (res.status != dcfp_pkg::ST_OK) begin
            // drop decoded fields on any parameter or command error
            o_result.status  = res.status;
            o_result.command = res.command;
        end else begin
            o_result = res;
        end
    end

endmodule

// File: sv/display_command_frame_parser.sv
// ============================================================================
// display_command_frame_parser - display command frame parser top level
// Byte-stream frame checker and command decoder with an output register.
// ============================================================================
// Takes one frame byte per clock on i_frame, with frame_end set on the last
// byte of each frame. Bytes that are not the last one produce no result; the
// last byte is checked and decoded in the same cycle it is transferred and
// its result appears in the output register on the next cycle, so a new frame
// may start right behind it. Input ready drops only while a result sits in
// the output register and the sink does not take it. The frame length
// limits are written through the APB port (minimum at 0x0, maximum at 0x4)
// and should only change between frames.
module display_command_frame_parser #(
    parameter int unsigned PAYLOAD_HEAD_BYTES = dcfp_pkg::PAYLOAD_HEAD_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dcfp_byte_if.sink                     i_frame,
    dcfp_result_if.source                 o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcfp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [dcfp_pkg::COUNT_W-1:0]       min_frame;
    logic [dcfp_pkg::COUNT_W-1:0]       max_frame;
    dcfp_pkg::t_frame_info              info;
    logic [PAYLOAD_HEAD_BYTES-1:0][7:0] head;
    dcfp_pkg::t_result                  dec_res;
    dcfp_pkg::t_result                  r_res;
    logic                               r_out_valid;
    logic                               in_fire;
    logic                               last_fire;

    assign i_frame.ready = !r_out_valid || o_result.ready;
    assign in_fire       = i_frame.valid && i_frame.ready;
    assign last_fire     = in_fire && i_frame.frame_end;

    dcfp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_min_frame (min_frame),
        .o_max_frame (max_frame)
    );

    dcfp_frame_track #(
        .PAYLOAD_HEAD_BYTES (PAYLOAD_HEAD_BYTES)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_fire),
        .i_data_byte (i_frame.data_byte),
        .i_frame_end (i_frame.frame_end),
        .o_info      (info),
        .o_head      (head)
    );

    dcfp_decode #(
        .PAYLOAD_HEAD_BYTES (PAYLOAD_HEAD_BYTES)
    ) u_decode (
        .i_info      (info),
        .i_head      (head),
        .i_data_byte (i_frame.data_byte),
        .i_min_frame (min_frame),
        .i_max_frame (max_frame),
        .o_result    (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (last_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_fire) begin
            r_res <= dec_res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_res.status;
    assign o_result.command     = r_res.command;
    assign o_result.param_a     = r_res.param_a;
    assign o_result.param_b     = r_res.param_b;
    assign o_result.param_c     = r_res.param_c;
    assign o_result.text_count  = r_res.text_count;
    assign o_result.ip_address  = r_res.ip_address;
    assign o_result.net_mask    = r_res.net_mask;
    assign o_result.gateway     = r_res.gateway;
    assign o_result.port_number = r_res.port_number;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_fire |=> o_result.valid)
        else $error("last byte transfer produced no result");

    a_taken_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ready && !last_fire) |=> !o_result.valid)
        else $error("result repeated after transfer");

    a_error_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != dcfp_pkg::ST_OK) |->
        (o_result.param_a == 8'd0 && o_result.param_b == 8'd0
         && o_result.param_c == 8'd0 && o_result.text_count == 8'd0
         && o_result.ip_address == 32'd0 && o_result.port_number == 16'd0))
        else $error("error result carries decoded fields");

    a_frame_err_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status == dcfp_pkg::ST_FRAME_ERR) |->
        (o_result.command == 8'd0))
        else $error("frame error reports a command");

endmodule

// File: tb/sv/display_command_frame_parser_test.sv
`timescale 1ns / 100ps
// ============================================================================
// display_command_frame_parser_test - frame parser self-checking bench
// Feeds frame bytes with random source and sink stalls, predicts each frame
// status and decoded fields in the bench, and checks every parse result.
// The length limits are reprogrammed between phases through the APB port.
// ============================================================================
module display_command_frame_parser_test;
    import dcfp_pkg::*;

    localparam logic [7:0] CMD_STATUS_OUT = 8'h51;  // outbound only, never accepted
    localparam int         RUN_LIMIT      = 400000;

    typedef enum int {FR_CLEAN, FR_BAD_START, FR_BAD_END, FR_BAD_LEN} t_flaw;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    dcfp_byte_if   frame_bus ();
    dcfp_result_if result_bus ();

    // frame predictor state
    logic [COUNT_W-1:0]  cfg_min;
    logic [COUNT_W-1:0]  cfg_max;
    logic [COUNT_W-1:0]  seen_count;
    logic                seen_start;
    logic [7:0]          seen_cmd;
    logic [7:0]          seen_len;
    logic [7:0]          head_bytes [PAYLOAD_HEAD_BYTES];

    t_byte_item          pending_bytes [$];
    t_result             awaited_results [$];
    logic [7:0]          frame_args [$];
    logic [7:0]          cmd_menu [19] = '{
        CMD_FILL_COLOR, CMD_CTRL_02, CMD_NOARG_31, CMD_NOARG_32, CMD_LINE_TEXT,
        CMD_SCREEN_TEXT, CMD_NOARG_35, CMD_BRIGHTNESS, CMD_PERIPHERAL, CMD_ROW_CLR_0,
        CMD_ROW_CLR_1, CMD_ROW_CLR_2, CMD_ROW_CLR_3, CMD_ROW_CLR_4, CMD_NETWORK,
        CMD_NOARG_48, CMD_FONT, CMD_ROW_CLR_ALL, CMD_STATUS_OUT
    };

    int                  queued_bytes;
    int                  accepted_bytes;
    int                  mismatch_count;
    int                  run_cycles;
    int                  src_hold;
    int                  sink_hold;
    bit                  quiet;
    bit                  byte_fire;
    t_byte_item          next_byte;
    t_result             seen_result;
    t_result             want_result;

    display_command_frame_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_bus),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic t_result decode_command();
        t_result    r;
        t_status    st;
        logic [7:0] d;
        logic [7:0] p0;
        logic [7:0] p1;
        r         = '0;
        r.status  = ST_OK;
        r.command = seen_cmd;
        d         = seen_len;
        p0        = head_bytes[0];
        p1        = head_bytes[1];
        case (seen_cmd)
            CMD_NOARG_31, CMD_NOARG_32, CMD_NOARG_35, CMD_NOARG_48: begin
                if (d != 0) r.status = ST_PARAM_ERR;
            end
            CMD_LINE_TEXT, CMD_SCREEN_TEXT: begin
                // color is ASCII '0'..'2' or binary 0..2
                if (p0 >= ASCII_ZERO && p0 <= ASCII_TWO) begin
                    r.param_a = p0 - ASCII_ZERO;
                end else if (p0 <= BIN_COLOR_MAX) begin
                    r.param_a = p0;
                end else begin
                    r.status = ST_PARAM_ERR;
                end
                if (seen_cmd == CMD_SCREEN_TEXT) begin
                    r.param_b    = p1;
                    r.param_c    = head_bytes[2];
                    r.text_count = d - 8'd3;
                    if (d < 4) r.status = ST_PARAM_ERR;
                end else begin
                    r.text_count = d - 8'd2;
                    if (p1 >= ASCII_ONE && p1 <= ASCII_FIVE) begin
                        r.param_b = p1 - ASCII_ONE;
                    end else if (p1 >= 8'd1 && p1 <= BIN_ROW_MAX) begin
                        r.param_b = p1 - 8'd1;
                    end else begin
                        r.status = ST_PARAM_ERR;
                    end
                    if (d < 3) r.status = ST_PARAM_ERR;
                end
            end
            CMD_BRIGHTNESS: begin
                if (d != 1) begin
                    r.status = ST_PARAM_ERR;
                end else if (p0 == 8'd0 || p0 == ASCII_ZERO) begin
                    r.param_a = 8'd0;
                end else if (p0 >= ASCII_ONE && p0 <= ASCII_EIGHT) begin
                    r.param_a = p0 - ASCII_ZERO;
                end else begin
                    r.status = ST_PARAM_ERR;
                end
            end
            CMD_PERIPHERAL: begin
                r.param_a = p0;
                if (d != 1) r.status = ST_PARAM_ERR;
            end
            CMD_ROW_CLR_0, CMD_ROW_CLR_1, CMD_ROW_CLR_2, CMD_ROW_CLR_3, CMD_ROW_CLR_4: begin
                r.param_a = seen_cmd - CMD_ROW_CLR_0;
                if (d != 0) r.status = ST_PARAM_ERR;
            end
            CMD_ROW_CLR_ALL: begin
                r.param_a = ROW_ALL_CODE;
                if (d != 0) r.status = ST_PARAM_ERR;
            end
            CMD_NETWORK: begin
                r.ip_address  = {head_bytes[0], head_bytes[1], head_bytes[2], head_bytes[3]};
                r.net_mask    = {head_bytes[4], head_bytes[5], head_bytes[6], head_bytes[7]};
                r.gateway     = {head_bytes[8], head_bytes[9], head_bytes[10], head_bytes[11]};
                r.port_number = {head_bytes[12], head_bytes[13]};
                if (d < NET_HEAD_LEN) r.status = ST_PARAM_ERR;
            end
            CMD_FONT: begin
                r.param_a = p0;
                r.param_b = p1;
                if (d != 2 || p0 > FONT_TYPE_MAX || p1 > FONT_SIZE_MAX) r.status = ST_PARAM_ERR;
            end
            CMD_FILL_COLOR: begin
                r.param_a = p0;
                if (d != 1 || p0 < 8'd1 || p0 > FILL_MAX) r.status = ST_PARAM_ERR;
            end
            CMD_CTRL_02: begin
                if (d != 1) r.status = ST_PARAM_ERR;
            end
            default: r.status = ST_UNSUPPORTED;
        endcase
        // any rejection clears every decoded field
        if (r.status != ST_OK) begin
            st        = r.status;
            r         = '0;
            r.status  = st;
            r.command = seen_cmd;
        end
        return r;
    endfunction

    // Advance the frame state by one byte; returns 1 when a result is due.
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output t_result r);
        logic [COUNT_W-1:0] pos;
        bit                 framed;
        pos = seen_count;
        r   = '0;
        if (pos == 0) begin
            seen_start = (b == STX);
        end else if (pos == 1) begin
            seen_cmd = b;
        end else if (pos == 2) begin
            seen_len = b;
        end else if (pos < COUNT_W'(3 + PAYLOAD_HEAD_BYTES)) begin
            head_bytes[pos - 3] = b;
        end
        if (seen_count != COUNT_MAX) seen_count = seen_count + 1'b1;
        if (!last) return 1'b0;

        framed = seen_count >= MIN_FRAME_LEN && seen_count >= cfg_min &&
                 seen_count <= cfg_max && seen_start && b == ETX &&
                 (seen_count - MIN_FRAME_LEN) == {1'b0, seen_len};
        if (framed) begin
            r = decode_command();
        end else begin
            r.status = ST_FRAME_ERR;
        end
        seen_count = '0;
        seen_start = 1'b0;
        seen_cmd   = '0;
        seen_len   = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic last);
        t_byte_item item;
        item.data = b;
        item.last = last;
        pending_bytes.push_back(item);
        queued_bytes++;
    endtask

    // Frame around frame_args, with an optional framing flaw.
    task automatic push_frame(input logic [7:0] cmd, input t_flaw flaw);
        logic [7:0] len_byte;
        len_byte = 8'(frame_args.size());
        if (flaw == FR_BAD_LEN) len_byte = len_byte ^ (8'd1 << $urandom_range(0, 7));
        push_byte(flaw == FR_BAD_START ? STX ^ 8'($urandom_range(1, 255)) : STX, 1'b0);
        push_byte(cmd, 1'b0);
        push_byte(len_byte, 1'b0);
        foreach (frame_args[i]) push_byte(frame_args[i], 1'b0);
        push_byte(flaw == FR_BAD_END ? ETX ^ 8'($urandom_range(1, 255)) : ETX, 1'b1);
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), i == n - 1);
    endtask

    task automatic push_screen_text(input int text_bytes);
        frame_args = {ASCII_ONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
        repeat (text_bytes) frame_args.push_back(8'($urandom_range(0, 255)));
        push_frame(CMD_SCREEN_TEXT, FR_CLEAN);
    endtask

    // runs past the counter's saturation point
    task automatic push_overlong(input int n);
        frame_args = {};
        repeat (n) frame_args.push_back(8'($urandom_range(0, 255)));
        push_frame(CMD_NETWORK, FR_CLEAN);
    endtask

    // Arguments that are mostly legal for cmd, with random content.
    task automatic random_args(input logic [7:0] cmd, input int max_text);
        int n;
        frame_args = {};
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, max_text) : $urandom_range(0, 8);
        case (cmd)
            CMD_LINE_TEXT, CMD_SCREEN_TEXT: begin
                case ($urandom_range(0, 3))
                    0:       frame_args.push_back(ASCII_ZERO + 8'($urandom_range(0, 2)));
                    1:       frame_args.push_back(8'($urandom_range(0, 3)));
                    default: frame_args.push_back(8'($urandom_range(0, 255)));
                endcase
                if (cmd == CMD_LINE_TEXT) begin
                    case ($urandom_range(0, 3))
                        0:       frame_args.push_back(ASCII_ONE + 8'($urandom_range(0, 4)));
                        1:       frame_args.push_back(8'($urandom_range(0, 6)));
                        default: frame_args.push_back(8'($urandom_range(0, 255)));
                    endcase
                end else begin
                    frame_args.push_back(8'($urandom_range(0, 255)));
                    frame_args.push_back(8'($urandom_range(0, 255)));
                end
                repeat (n) frame_args.push_back(8'($urandom_range(0, 255)));
            end
            CMD_BRIGHTNESS: begin
                case ($urandom_range(0, 3))
                    0:       frame_args.push_back(8'd0);
                    3:       frame_args.push_back(8'($urandom_range(0, 255)));
                    default: frame_args.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
                endcase
            end
            CMD_PERIPHERAL, CMD_CTRL_02: frame_args.push_back(8'($urandom_range(0, 255)));
            CMD_FILL_COLOR: begin
                frame_args.push_back($urandom_range(0, 3) != 0 ? 8'($urandom_range(0, 8))
                                                               : 8'($urandom_range(0, 255)));
            end
            CMD_FONT: begin
                frame_args.push_back(8'($urandom_range(0, 4)));
                frame_args.push_back(8'($urandom_range(0, 3)));
            end
            CMD_NETWORK: repeat ($urandom_range(13, 17)) frame_args.push_back(8'($urandom_range(0, 255)));
            default: ;
        endcase
        // now and then the wrong argument count
        if ($urandom_range(0, 9) == 0) begin
            frame_args = {};
            repeat ($urandom_range(0, 3)) frame_args.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_frames(input int n_bytes, input int max_text);
        int         first;
        int         pick;
        logic [7:0] cmd;
        first = queued_bytes;
        while (queued_bytes - first < n_bytes) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                push_noise($urandom_range(1, 6));
            end else begin
                cmd = (pick == 2) ? 8'($urandom_range(0, 255))
                                  : cmd_menu[$urandom_range(0, 18)];
                random_args(cmd, max_text);
                push_frame(cmd, pick < 5 ? t_flaw'($urandom_range(1, 3)) : FR_CLEAN);
            end
        end
    endtask

    // Hold until every byte is taken and every result is in.
    task automatic wait_idle();
        while (accepted_bytes != queued_bytes || awaited_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic reg_idx, input logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_idx == REG_MIN_FRAME) cfg_min = value;
        else cfg_max = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: drive at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!frame_bus.valid || byte_fire) begin
                if (src_hold > 0) begin
                    src_hold--;
                    frame_bus.valid <= 1'b0;
                end else if (pending_bytes.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
                    src_hold = $urandom_range(0, 12);
                    frame_bus.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    next_byte = pending_bytes.pop_front();
                    frame_bus.valid     <= 1'b1;
                    frame_bus.data_byte <= next_byte.data;
                    frame_bus.frame_end <= next_byte.last;
                end else begin
                    frame_bus.valid <= 1'b0;
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                result_bus.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                sink_hold = $urandom_range(0, 12);
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: sample at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            byte_fire = frame_bus.valid && frame_bus.ready;
            if (byte_fire) begin
                accepted_bytes++;
                if (parse_byte(frame_bus.data_byte, frame_bus.frame_end, want_result))
                    awaited_results.push_back(want_result);
            end
            if (result_bus.valid && result_bus.ready) begin
                seen_result.status      = t_status'(result_bus.status);
                seen_result.command     = result_bus.command;
                seen_result.param_a     = result_bus.param_a;
                seen_result.param_b     = result_bus.param_b;
                seen_result.param_c     = result_bus.param_c;
                seen_result.text_count  = result_bus.text_count;
                seen_result.ip_address  = result_bus.ip_address;
                seen_result.net_mask    = result_bus.net_mask;
                seen_result.gateway     = result_bus.gateway;
                seen_result.port_number = result_bus.port_number;
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with none expected: %p", $realtime, seen_result);
                end else begin
                    want_result = awaited_results.pop_front();
                    compare_field("status", want_result.status, seen_result.status);
                    compare_field("command", want_result.command, seen_result.command);
                    compare_field("param_a", want_result.param_a, seen_result.param_a);
                    compare_field("param_b", want_result.param_b, seen_result.param_b);
                    compare_field("param_c", want_result.param_c, seen_result.param_c);
                    compare_field("text_count", want_result.text_count,
                                  seen_result.text_count);
                    compare_field("ip_address", want_result.ip_address, seen_result.ip_address);
                    compare_field("net_mask", want_result.net_mask, seen_result.net_mask);
                    compare_field("gateway", want_result.gateway, seen_result.gateway);
                    compare_field("port_number", want_result.port_number,
                                  seen_result.port_number);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        run_cycles++;
        if (run_cycles >= RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        frame_bus.valid      = 1'b0;
        frame_bus.data_byte  = '0;
        frame_bus.frame_end  = 1'b0;
        result_bus.ready     = 1'b0;
        cfg_min              = CFG_MIN_RESET;
        cfg_max              = CFG_MAX_RESET;
        seen_count           = '0;
        seen_start           = 1'b0;
        seen_cmd             = '0;
        seen_len             = '0;
        foreach (head_bytes[i]) head_bytes[i] = '0;
        quiet                = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames at the reset limits
        frame_args = {};
        push_frame(CMD_NOARG_31, FR_CLEAN);
        push_frame(CMD_NOARG_32, FR_CLEAN);
        push_frame(CMD_NOARG_35, FR_CLEAN);
        push_frame(CMD_ROW_CLR_0, FR_CLEAN);
        push_frame(CMD_ROW_CLR_1, FR_CLEAN);
        push_frame(CMD_ROW_CLR_2, FR_CLEAN);
        push_frame(CMD_ROW_CLR_3, FR_CLEAN);
        push_frame(CMD_ROW_CLR_4, FR_CLEAN);
        push_frame(CMD_ROW_CLR_ALL, FR_CLEAN);
        push_frame(CMD_STATUS_OUT, FR_CLEAN);
        push_frame(8'hFF, FR_CLEAN);
        push_frame(CMD_NOARG_31, FR_BAD_START);
        push_frame(CMD_NOARG_31, FR_BAD_END);
        push_frame(CMD_NOARG_31, FR_BAD_LEN);
        frame_args = {8'h00};
        push_frame(CMD_NOARG_48, FR_CLEAN);
        push_frame(CMD_CTRL_02, FR_CLEAN);
        push_frame(CMD_BRIGHTNESS, FR_CLEAN);
        push_frame(CMD_FILL_COLOR, FR_CLEAN);
        frame_args = {ASCII_EIGHT};
        push_frame(CMD_BRIGHTNESS, FR_CLEAN);
        frame_args = {8'h39};
        push_frame(CMD_BRIGHTNESS, FR_CLEAN);
        frame_args = {8'hFF};
        push_frame(CMD_PERIPHERAL, FR_CLEAN);
        frame_args = {8'd1};
        push_frame(CMD_FILL_COLOR, FR_CLEAN);
        frame_args = {FILL_MAX};
        push_frame(CMD_FILL_COLOR, FR_CLEAN);
        frame_args = {ASCII_ZERO, ASCII_ONE, 8'h41, 8'h42};
        push_frame(CMD_LINE_TEXT, FR_CLEAN);
        frame_args = {BIN_COLOR_MAX, BIN_ROW_MAX, 8'hFF};
        push_frame(CMD_LINE_TEXT, FR_CLEAN);
        frame_args = {ASCII_TWO, 8'hFF, 8'h00, 8'h7D};
        push_frame(CMD_SCREEN_TEXT, FR_CLEAN);
        frame_args = {FONT_TYPE_MAX, FONT_SIZE_MAX};
        push_frame(CMD_FONT, FR_CLEAN);
        frame_args = {8'd4, 8'd0};
        push_frame(CMD_FONT, FR_CLEAN);
        frame_args = {8'hC0, 8'hA8, 8'h01, 8'h64, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                      8'hC0, 8'hA8, 8'h01, 8'h01, 8'h1F, 8'h90};
        push_frame(CMD_NETWORK, FR_CLEAN);
        // short frames: one byte, then start, command and end only
        push_byte(STX, 1'b1);
        push_byte(STX, 1'b0);
        push_byte(CMD_NOARG_31, 1'b0);
        push_byte(ETX, 1'b1);
        wait_idle();

        random_frames(60, 40);
        push_overlong(508);
        wait_idle();

        // only frames of exactly the top length pass
        cfg_write(REG_MAX_FRAME, 9'd259);
        cfg_write(REG_MIN_FRAME, 9'd259);
        push_screen_text(252);
        frame_args = {};
        push_frame(CMD_NOARG_31, FR_CLEAN);
        wait_idle();

        // only four-byte frames pass
        cfg_write(REG_MIN_FRAME, 9'd4);
        cfg_write(REG_MAX_FRAME, 9'd4);
        random_frames(40, 8);
        wait_idle();

        // crossed limits reject everything
        cfg_write(REG_MIN_FRAME, 9'd40);
        cfg_write(REG_MAX_FRAME, 9'd20);
        random_frames(40, 40);
        wait_idle();

        cfg_write(REG_MIN_FRAME, 9'd10);
        cfg_write(REG_MAX_FRAME, 9'd30);
        random_frames(40, 26);
        wait_idle();

        // back to the reset limits, full rate on both sides
        cfg_write(REG_MIN_FRAME, CFG_MIN_RESET);
        cfg_write(REG_MAX_FRAME, CFG_MAX_RESET);
        quiet = 1'b1;
        random_frames(60, 60);
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/dcfp_pkg.sv
sv/dcfp_if.sv
sv/dcfp_cfg_regs.sv
sv/dcfp_frame_track.sv
sv/dcfp_decode.sv
sv/display_command_frame_parser.sv
tb/sv/display_command_frame_parser_test.sv
